@@ hdl/time_bin_count_table_macros.svh @@
// assertion macros shared by the checker
`ifndef TIME_BIN_COUNT_TABLE_MACROS_SVH
`define TIME_BIN_COUNT_TABLE_MACROS_SVH
// implication checked every clock edge outside reset
`define TBC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication outside reset
`define TBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ hdl/tbc_pkg.sv @@
package tbc_pkg;
  localparam int unsigned NumBinsDefault = 32;
  localparam int unsigned MaxResults = 32;
  localparam logic [30:0] BinMax = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    REQ_INSERT  = 3'd0,
    REQ_REMOVE  = 3'd1,
    REQ_RANGE_I = 3'd2,
    REQ_RANGE_G = 3'd3,
    REQ_BOUNDS  = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BACKWARD = 3'd1,
    ST_FULL     = 3'd2,
    ST_NONE     = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV0, S_DIVW0, S_DIV1, S_DIVW1, S_DECIDE, S_SCAN, S_SHIFT,
    S_BMUL0, S_BMUL1, S_BWAIT, S_EMIT, S_NONE
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture request
    logic div_start;
    logic div_sel;    // 0 value or begin, 1 end
    logic dec_exec;   // insert/remove decisions at scan start
    logic scan_clr;
    logic scan_step;
    logic shift_step;
    logic mul_start;
    logic mul_sel;    // 0 first bin, 1 last bin
    logic emit_none;
    logic emit_scan;
    logic emit_single;
    logic emit_bounds;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [2:0] req;
    logic div_done;
    logic mul_done;
    logic single_ready;  // insert result formed in decide
    logic scan_end;
    logic scan_hit;
    logic scan_last;     // current range hit is the final one
    logic scan_stop;     // remove stops scan
    logic rm_free;       // remove emptied bin, needs shift
    logic shift_end;
    logic empty;
    logic out_busy;
  } stat_t;
endpackage

@@ hdl/tbc_datapath.sv @@
module tbc_datapath
  import tbc_pkg::*;
#(
  parameter int unsigned NumBins = NumBinsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic        cfg_valid_i,
  input  logic [31:0] cfg_data_i,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] value_i,
  input  logic [31:0] range_begin_i,
  input  logic [31:0] range_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [30:0] bin_number_o,
  output logic [30:0] bin_count_o,
  output logic        bin_freed_o,
  output logic [30:0] rel_index_o,
  output logic [31:0] low_bound_o,
  output logic [31:0] high_bound_o,
  output logic [31:0] total_items_o,
  output logic        last_o
);
  localparam int unsigned IW = $clog2(NumBins);
  localparam int unsigned CW = $clog2(NumBins + 1);
  localparam logic [CW-1:0] Full = CW'(NumBins);

  logic [30:0] nums_q [NumBins];
  logic [30:0] cnts_q [NumBins];
  logic [CW-1:0] used_q;
  logic [31:0] total_q;
  logic [31:0] bsize_q;
  logic [2:0]  req_q;
  logic [31:0] val_q, beg_q, end_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q <= 32'd1;
    end else if (cfg_valid_i) begin
      bsize_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      val_q <= value_i;
      beg_q <= range_begin_i;
      end_q <= range_end_i;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [31:0] dq_q, dr_q, dsor;
  logic [5:0]  dcnt_q;
  logic        dbusy_q, ddone_q;
  logic [32:0] dtrial;
  logic [31:0] qa_q, qb_q;
  assign dsor = (bsize_q == 32'd0) ? 32'd1 : bsize_q;
  assign dtrial = {dr_q, dq_q[31]} - {1'b0, dsor};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      ddone_q <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      ddone_q <= !cmd_i.div_start && dbusy_q && (dcnt_q == 6'd31);
      if (cmd_i.div_start) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= 6'd0;
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q + 6'd1;
        if (dcnt_q == 6'd31) begin
          dbusy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dq_q <= cmd_i.div_sel ? end_q :
              ((req_q == REQ_INSERT || req_q == REQ_REMOVE) ? val_q : beg_q);
      dr_q <= '0;
    end else if (dbusy_q) begin
      if (!dtrial[32]) begin
        dr_q <= dtrial[31:0];
        dq_q <= {dq_q[30:0], 1'b1};
      end else begin
        dr_q <= {dr_q[30:0], dq_q[31]};
        dq_q <= {dq_q[30:0], 1'b0};
      end
    end
    if (ddone_q) begin
      if (cmd_i.div_sel) qb_q <= dq_q;
      else qa_q <= dq_q;
    end
  end

  // range end after widening, 33 bits
  logic [32:0] t1;
  assign t1 = (qa_q == qb_q) ? {1'b0, qb_q} + 33'd1 : {1'b0, qb_q};

  // scan pointer and per-entry compare
  logic [IW-1:0] idx_q;
  logic          idx_end_q;
  logic [30:0]   enum_v, ecnt_v;
  assign enum_v = nums_q[idx_q];
  assign ecnt_v = cnts_q[idx_q];
  logic in_rng;
  always_comb begin
    if (req_q == REQ_RANGE_G) in_rng = ({1'b0, enum_v} >= qa_q) && ({2'b0, enum_v} < t1);
    else in_rng = ({1'b0, enum_v} >= qa_q) && ({2'b0, enum_v} <= t1);
  end
  logic rm_match, rm_stop;
  assign rm_match = {1'b0, enum_v} == qa_q;
  assign rm_stop  = {1'b0, enum_v} > qa_q;

  logic [CW-1:0] idx_ext;
  assign idx_ext = CW'(idx_q);
  logic [5:0] kcnt_q;

  // lookahead at the next entry: hits are contiguous in the sorted table,
  // so a hit is the final one when the next entry misses, the table ends or the result limit is reached
  logic [CW-1:0] nxt_ext;
  logic [30:0]   nxt_num;
  logic          nxt_in, scan_last;
  assign nxt_ext = idx_ext + CW'(1);
  assign nxt_num = nums_q[IW'(nxt_ext)];
  always_comb begin
    if (req_q == REQ_RANGE_G) nxt_in = ({1'b0, nxt_num} >= qa_q) && ({2'b0, nxt_num} < t1);
    else nxt_in = ({1'b0, nxt_num} >= qa_q) && ({2'b0, nxt_num} <= t1);
  end
  assign scan_last = (nxt_ext >= used_q) || !nxt_in || (kcnt_q == 6'(MaxResults - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      idx_end_q <= 1'b0;
      kcnt_q <= '0;
    end else if (cmd_i.scan_clr) begin
      idx_q <= '0;
      idx_end_q <= 1'b0;
      kcnt_q <= '0;
    end else if (cmd_i.scan_step || cmd_i.shift_step) begin
      if (cmd_i.emit_scan) kcnt_q <= kcnt_q + 6'd1;
      if (idx_ext == CW'(NumBins - 1)) idx_end_q <= 1'b1;
      else idx_q <= idx_q + IW'(1);
    end
  end

  logic scan_end;
  assign scan_end = idx_end_q || (idx_ext >= used_q) || (kcnt_q == 6'(MaxResults));

  // multiplier for bounds
  logic [31:0] mres_q, lo_q;
  logic        mdone_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mdone_q <= 1'b0;
    else mdone_q <= cmd_i.mul_start;
  end
  logic [30:0] mop;
  assign mop = cmd_i.mul_sel ? nums_q[IW'(used_q - CW'(1))] : nums_q[0];
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) mres_q <= 32'({1'b0, mop} * dsor);
    // first product is still in mres_q when the second one starts
    if (cmd_i.mul_start && cmd_i.mul_sel) lo_q <= mres_q;
  end

  // insert decision
  logic [30:0] last_num, last_cnt;
  assign last_num = nums_q[IW'(used_q - CW'(1))];
  assign last_cnt = cnts_q[IW'(used_q - CW'(1))];

  // output register
  logic        ov_q;
  logic [2:0]  st_q;
  logic [30:0] bn_q, bc_q, ri_q;
  logic        bf_q, lst_q;
  logic [31:0] lob_q, hib_q;

  function automatic logic [31:0] tot_inc(input logic [31:0] t);
    return (t == 32'h7FFF_FFFF) ? t : t + 32'd1;
  endfunction
  function automatic logic [31:0] tot_dec(input logic [31:0] t);
    return (t == 32'h8000_0000) ? t : t - 32'd1;
  endfunction

  logic [CW-1:0] last_pos;
  assign last_pos = used_q - CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      used_q <= '0;
      total_q <= '0;
    end else begin
      if (cmd_i.emit_none || cmd_i.emit_single || cmd_i.emit_bounds ||
          cmd_i.emit_scan) ov_q <= 1'b1;
      else if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (cmd_i.dec_exec && req_q == REQ_INSERT && qa_q[31] == 1'b0) begin
        if (used_q != '0 && qa_q[30:0] == last_num) begin
          if (last_cnt != BinMax) total_q <= tot_inc(total_q);
        end else if (!(used_q != '0 && qa_q[30:0] < last_num) && used_q != Full) begin
          used_q <= used_q + CW'(1);
          total_q <= tot_inc(total_q);
        end
      end
      if (cmd_i.dec_exec && req_q == REQ_REMOVE) total_q <= tot_dec(total_q);
      if (cmd_i.shift_step && (idx_ext >= last_pos)) used_q <= used_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dec_exec && req_q == REQ_INSERT && qa_q[31] == 1'b0) begin
      if (used_q != '0 && qa_q[30:0] == last_num) begin
        if (last_cnt != BinMax) cnts_q[IW'(last_pos)] <= last_cnt + 31'd1;
      end else if (!(used_q != '0 && qa_q[30:0] < last_num) && used_q != Full) begin
        nums_q[IW'(used_q)] <= qa_q[30:0];
        cnts_q[IW'(used_q)] <= 31'd1;
      end
    end
    if (cmd_i.scan_step && req_q == REQ_REMOVE && rm_match && !scan_end)
      cnts_q[idx_q] <= ecnt_v - 31'd1;
    if (cmd_i.shift_step && (idx_ext < last_pos)) begin
      nums_q[idx_q] <= nums_q[IW'(idx_ext + CW'(1))];
      cnts_q[idx_q] <= cnts_q[IW'(idx_ext + CW'(1))];
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_none) begin
      st_q <= ST_NONE;
      bn_q <= (req_q == REQ_REMOVE && !qa_q[31]) ? qa_q[30:0] : 31'd0;
      bc_q <= '0; bf_q <= 1'b0; ri_q <= '0; lob_q <= '0; hib_q <= '0;
      lst_q <= 1'b1;
    end else if (cmd_i.emit_single) begin
      ri_q <= '0; lob_q <= '0; hib_q <= '0; lst_q <= 1'b1;
      bf_q <= (req_q == REQ_REMOVE) && (ecnt_v == 31'd1);
      bn_q <= (req_q != REQ_REMOVE && qa_q[31]) ? 31'd0 : qa_q[30:0];
      if (req_q == REQ_REMOVE) begin
        st_q <= ST_OK; bc_q <= ecnt_v - 31'd1;
      end else if (qa_q[31]) begin
        st_q <= ST_OVERFLOW; bc_q <= '0;
      end else if (used_q != '0 && qa_q[30:0] == last_num) begin
        if (last_cnt == BinMax) begin
          st_q <= ST_OVERFLOW; bc_q <= last_cnt;
        end else begin
          st_q <= ST_OK; bc_q <= last_cnt + 31'd1;
        end
      end else if (used_q != '0 && qa_q[30:0] < last_num) begin
        st_q <= ST_BACKWARD; bc_q <= '0;
      end else if (used_q == Full) begin
        st_q <= ST_FULL; bc_q <= '0;
      end else begin
        st_q <= ST_OK; bc_q <= 31'd1;
      end
    end else if (cmd_i.emit_scan) begin
      st_q <= ST_OK; bn_q <= enum_v; bc_q <= ecnt_v; bf_q <= 1'b0;
      ri_q <= (req_q == REQ_RANGE_G) ? 31'(enum_v - qa_q[30:0]) : 31'd0;
      lob_q <= '0; hib_q <= '0;
      lst_q <= scan_last;
    end else if (cmd_i.emit_bounds) begin
      st_q <= ST_OK; bn_q <= '0; bc_q <= '0; bf_q <= 1'b0; ri_q <= '0;
      lob_q <= lo_q; hib_q <= mres_q; lst_q <= 1'b1;
    end
  end

  assign stat_o.req = req_q;
  assign stat_o.div_done = ddone_q;
  assign stat_o.mul_done = mdone_q;
  assign stat_o.single_ready = 1'b1;
  assign stat_o.scan_end = scan_end;
  assign stat_o.scan_hit = (req_q == REQ_REMOVE) ? rm_match : in_rng;
  assign stat_o.scan_last = scan_last;
  assign stat_o.scan_stop = rm_stop;
  assign stat_o.rm_free = (ecnt_v == 31'd1);
  assign stat_o.shift_end = idx_end_q || (idx_ext >= last_pos);
  assign stat_o.empty = (used_q == '0);
  assign stat_o.out_busy = ov_q && !out_ready_i;

  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign bin_number_o = bn_q;
  assign bin_count_o = bc_q;
  assign bin_freed_o = bf_q;
  assign rel_index_o = ri_q;
  assign low_bound_o = lob_q;
  assign high_bound_o = hib_q;
  assign total_items_o = total_q;
  assign last_o = lst_q;
endmodule

@@ hdl/tbc_ctrl.sv @@
module tbc_ctrl
  import tbc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  cfg_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    cfg_ready_o = (state_q == S_IDLE) && !stat_i.out_busy;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = !stat_i.out_busy;
        if (in_valid_i && !stat_i.out_busy) begin
          cmd_o.load = 1'b1;
          state_d = S_DIV0;
        end
      end
      S_DIV0: begin
        if (stat_i.req == REQ_BOUNDS) begin
          if (stat_i.empty) state_d = S_NONE;
          else begin
            cmd_o.mul_start = 1'b1;
            state_d = S_BMUL0;
          end
        end else if (stat_i.req > REQ_BOUNDS) begin
          state_d = S_NONE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIVW0;
        end
      end
      S_DIVW0: if (stat_i.div_done) state_d = S_DIV1;
      S_DIV1: begin
        if (stat_i.req == REQ_RANGE_I || stat_i.req == REQ_RANGE_G) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel = 1'b1;
          state_d = S_DIVW1;
        end else state_d = S_DECIDE;
      end
      S_DIVW1: begin
        cmd_o.div_sel = 1'b1;
        if (stat_i.div_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.scan_clr = 1'b1;
        if (stat_i.req == REQ_INSERT) begin
          if (!stat_i.out_busy) begin
            cmd_o.emit_single = 1'b1;
            cmd_o.dec_exec = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          if (stat_i.req == REQ_REMOVE) cmd_o.dec_exec = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_end) begin
          state_d = (stat_i.req == REQ_REMOVE) ? S_NONE : S_EMIT;
        end else if (stat_i.req == REQ_REMOVE) begin
          if (stat_i.scan_hit) begin
            if (!stat_i.out_busy) begin
              cmd_o.emit_single = 1'b1;
              if (stat_i.rm_free) state_d = S_SHIFT;
              else begin
                cmd_o.scan_step = 1'b1;
                state_d = S_IDLE;
              end
            end
          end else if (stat_i.scan_stop) state_d = S_NONE;
          else cmd_o.scan_step = 1'b1;
        end else if (stat_i.scan_hit) begin
          if (!stat_i.out_busy) begin
            cmd_o.emit_scan = 1'b1;
            cmd_o.scan_step = 1'b1;
            if (stat_i.scan_last) state_d = S_IDLE;
          end
        end else cmd_o.scan_step = 1'b1;
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (stat_i.shift_end) state_d = S_IDLE;
      end
      S_BMUL0: if (stat_i.mul_done) begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel = 1'b1;
        state_d = S_BMUL1;
      end
      S_BMUL1: begin
        cmd_o.mul_sel = 1'b1;
        if (stat_i.mul_done) state_d = S_BWAIT;
      end
      S_BWAIT: begin
        cmd_o.mul_sel = 1'b1;
        if (!stat_i.out_busy) begin
          cmd_o.emit_bounds = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EMIT: state_d = S_NONE;
      S_NONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit_none = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

@@ hdl/time_bin_count_table.sv @@
// time bin table: one transaction in flight, a bit-serial divide by bin size
// steps to first result: bounds two multiplies, insert one divide, remove a divide
// then the scan, range queries a second divide for the end, then the scan
// the next transaction is taken once the controller is back in idle and no result
// is stalled; a freed bin first shifts the tail before the return to idle
// reset: asynchronous active low, table empty, total zero, bin size one
module time_bin_count_table
  import tbc_pkg::*;
#(
  parameter int unsigned NUM_BINS = NumBinsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] value_i,
  input  logic [31:0] range_begin_i,
  input  logic [31:0] range_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [30:0] bin_number_o,
  output logic [30:0] bin_count_o,
  output logic        bin_freed_o,
  output logic [30:0] rel_index_o,
  output logic [31:0] low_bound_o,
  output logic [31:0] high_bound_o,
  output logic [31:0] total_items_o,
  output logic        last_o
);
  cmd_t  cmd;
  stat_t stat;

  tbc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cfg_ready_o,
    .stat_i(stat), .cmd_o(cmd)
  );

  tbc_datapath #(.NumBins(NUM_BINS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .cfg_valid_i(cfg_valid_i && cfg_ready_o), .cfg_data_i,
    .req_type_i, .value_i, .range_begin_i, .range_end_i,
    .out_valid_o, .out_ready_i, .status_o, .bin_number_o, .bin_count_o,
    .bin_freed_o, .rel_index_o, .low_bound_o, .high_bound_o,
    .total_items_o, .last_o
  );
endmodule

@@ hdl/tbc_checker.sv @@
`include "time_bin_count_table_macros.svh"
module tbc_checker
  import tbc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic [2:0] status_o
);
  // no new transaction while a result waits
  `TBC_ASSERT_IMPL(a_no_accept_stalled, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o)
  // a stalled result holds
  `TBC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  // status codes stay in range
  `TBC_ASSERT_IMPL(a_status_range, clk_i, rst_ni, out_valid_o, status_o <= ST_OVERFLOW)
  // accept leads to a busy block next cycle
  `TBC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
endmodule

bind time_bin_count_table tbc_checker u_tbc_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .status_o
);
